[design/qrv_pkg.sv]
// shared widths and types for the quaternion vector rotation pipeline
`default_nettype none
package qrv_pkg;
  localparam int DataW  = 16;
  localparam int ProdW  = 32;
  localparam int SumW   = 34;
  localparam int WideW  = 50;
  localparam int NumW   = 53;
  localparam int DenW   = 33;
  localparam int DivW   = 34;
  localparam int RemW   = 56;
  localparam int QuotW  = 17;
  localparam int Steps  = 17;
  localparam int LaneLat = Steps + 1;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [QuotW-1:0] quot_t;

  typedef struct packed {
    logic neg;
    logic ovf;
  } lane_flags_t;
endpackage
`default_nettype wire

[design/qrv_div_lane.sv]
// pipelined rounding divider for one vector component, one quotient bit per stage
`default_nettype none
module qrv_div_lane
  import qrv_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [NumW-1:0] num,
  input  logic [DenW-1:0]        den,
  output quot_t                  quot,
  output lane_flags_t            flags
);
  logic [RemW-1:0] rem   [0:Steps];
  logic [DivW-1:0] dvs   [0:Steps];
  quot_t           qacc  [0:Steps];
  lane_flags_t     flg   [0:Steps];

  logic [RemW-1:0] rem_next  [0:Steps-1];
  quot_t           qacc_next [0:Steps-1];
  logic            ovf_chk;
  lane_flags_t     flg1_next;

  logic [NumW-1:0] mag;
  assign mag = num[NumW-1] ? NumW'(-num) : NumW'(num);

  // rounding numerator 2|num| + den over divisor 2 den
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]      <= RemW'({mag, 1'b0}) + RemW'(den);
      dvs[0]      <= {den, 1'b0};
      qacc[0]     <= '0;
      flg[0].neg  <= num[NumW-1];
      flg[0].ovf  <= 1'b0;
    end
  end

  // quotient beyond 17 bits always saturates
  assign ovf_chk = rem[0] >= (RemW'(dvs[0]) << Steps);

  always_comb begin
    flg1_next     = flg[0];
    flg1_next.ovf = flg[0].ovf | ovf_chk;
  end

  always_comb begin
    for (int j = 0; j < Steps; j++) begin
      if (rem[j] >= (RemW'(dvs[j]) << (Steps - 1 - j))) begin
        rem_next[j]  = rem[j] - (RemW'(dvs[j]) << (Steps - 1 - j));
        qacc_next[j] = qacc[j] | (QuotW'(1) << (Steps - 1 - j));
      end else begin
        rem_next[j]  = rem[j];
        qacc_next[j] = qacc[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < Steps; j++) begin
        rem[j+1]  <= rem_next[j];
        qacc[j+1] <= qacc_next[j];
        dvs[j+1]  <= dvs[j];
      end
      flg[1] <= flg1_next;
      for (int j = 1; j < Steps; j++) begin
        flg[j+1] <= flg[j];
      end
    end
  end

  assign quot  = qacc[Steps];
  assign flags = flg[Steps];
endmodule
`default_nettype wire

[design/quaternion_rotate_vector_top.sv]
// top level: pipelined rotation of a vector by a quaternion, q v q* / |q|^2
`default_nettype none
// usage
//   input channel: vec_x/y/z (Q7.8) and quat_x/y/z/w (Q1.14), transfer on
//   in_valid && in_ready. output channel: rot_x/y/z (Q7.8), zero_quat and
//   saturated, transfer on out_valid && out_ready.
//   one result per input item, in order. from the input transfer to
//   out_valid an item passes the product and sum stages, a setup
//   register plus 17 restoring-division stages (one quotient bit each,
//   three lanes in parallel) and the output register. throughput is
//   one item per cycle outside stalls; the division stage chain sets the depth.
//   the whole pipeline advances on one enable, which is low only while the
//   output register holds a result that the receiver does not take; then
//   in_ready drops and every stage holds its item, so nothing is lost or
//   repeated. reset clears the valid bits only; data registers are not reset.
//   an all-zero quaternion gives zero components, zero_quat high and
//   saturated low. components are rounded to nearest, ties away from zero,
//   and clipped to the 16-bit range with saturated raised.
module quaternion_rotate_vector_top
  import qrv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  data_t vec_x,
  input  data_t vec_y,
  input  data_t vec_z,
  input  data_t quat_x,
  input  data_t quat_y,
  input  data_t quat_z,
  input  data_t quat_w,
  output logic  out_valid,
  input  logic  out_ready,
  output data_t rot_x,
  output data_t rot_y,
  output data_t rot_z,
  output logic  zero_quat,
  output logic  saturated
);
  localparam int Lat = 4 + LaneLat + 1;

  logic en;
  logic [Lat-1:0] vld;

  // single pipeline enable: move whenever the output slot frees up
  assign en        = !vld[Lat-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end

  // stage 1: all 16x16 products
  logic signed [ProdW-1:0] p_xx, p_yy, p_zz, p_ww;
  logic signed [ProdW-1:0] p_uv [0:2][0:2];
  data_t v1 [0:2];
  data_t u1 [0:2];
  data_t w1;
  data_t vin [0:2];
  data_t uin [0:2];

  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;
  assign uin[0] = quat_x;
  assign uin[1] = quat_y;
  assign uin[2] = quat_z;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
      p_ww <= quat_w * quat_w;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_uv[i][j] <= uin[i] * vin[j];
        end
        v1[i] <= vin[i];
        u1[i] <= uin[i];
      end
      w1 <= quat_w;
    end
  end

  // stage 2: norm, scalar term, dot and cross products
  logic signed [SumW-1:0] s2, ud2, n2;
  logic signed [SumW-1:0] cr2 [0:2];
  data_t v2 [0:2];
  data_t u2 [0:2];
  data_t w2;

  always_ff @(posedge clk) begin
    if (en) begin
      n2  <= SumW'(p_ww) + SumW'(p_xx) + SumW'(p_yy) + SumW'(p_zz);
      s2  <= SumW'(p_ww) - SumW'(p_xx) - SumW'(p_yy) - SumW'(p_zz);
      ud2 <= SumW'(p_uv[0][0]) + SumW'(p_uv[1][1]) + SumW'(p_uv[2][2]);
      cr2[0] <= SumW'(p_uv[1][2]) - SumW'(p_uv[2][1]);
      cr2[1] <= SumW'(p_uv[2][0]) - SumW'(p_uv[0][2]);
      cr2[2] <= SumW'(p_uv[0][1]) - SumW'(p_uv[1][0]);
      v2 <= v1;
      u2 <= u1;
      w2 <= w1;
    end
  end

  // stage 3: second layer of products
  logic signed [WideW-1:0] sv3 [0:2];
  logic signed [WideW-1:0] ut3 [0:2];
  logic signed [WideW-1:0] wc3 [0:2];
  logic [DenW-1:0] n3;
  logic            z3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sv3[i] <= s2 * v2[i];
        ut3[i] <= ud2 * u2[i];
        wc3[i] <= cr2[i] * w2;
      end
      n3 <= DenW'(n2);
      z3 <= (n2 == '0);
    end
  end

  // stage 4: numerators
  logic signed [NumW-1:0] num4 [0:2];
  logic [DenW-1:0] n4;
  logic            z4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num4[i] <= NumW'(sv3[i]) + (NumW'(ut3[i]) <<< 1) + (NumW'(wc3[i]) <<< 1);
      end
      n4 <= n3;
      z4 <= z3;
    end
  end

  // division lanes
  quot_t       lq [0:2];
  lane_flags_t lf [0:2];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    qrv_div_lane u_lane (
      .clk   (clk),
      .en    (en),
      .num   (num4[g]),
      .den   (n4),
      .quot  (lq[g]),
      .flags (lf[g])
    );
  end

  // zero flag rides alongside the lanes
  logic [LaneLat-1:0] zpipe;
  always_ff @(posedge clk) begin
    if (en) begin
      zpipe <= {zpipe[LaneLat-2:0], z4};
    end
  end

  // final stage: sign, clipping and zero override
  localparam quot_t Lim = quot_t'(1) << (DataW - 1);
  data_t rc_next [0:2];
  logic  [2:0] sc_next;
  data_t rc [0:2];
  logic  zq;
  logic  sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lf[i].neg) begin
        if (lf[i].ovf || lq[i] > Lim) begin
          sc_next[i] = 1'b1;
          rc_next[i] = data_t'(-Lim);
        end else begin
          sc_next[i] = 1'b0;
          rc_next[i] = data_t'(-lq[i]);
        end
      end else begin
        if (lf[i].ovf || lq[i] > Lim - 1'b1) begin
          sc_next[i] = 1'b1;
          rc_next[i] = data_t'(Lim - 1'b1);
        end else begin
          sc_next[i] = 1'b0;
          rc_next[i] = data_t'(lq[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zq <= zpipe[LaneLat-1];
      for (int i = 0; i < 3; i++) begin
        rc[i] <= zpipe[LaneLat-1] ? '0 : rc_next[i];
      end
      sat <= !zpipe[LaneLat-1] && (|sc_next);
    end
  end

  assign rot_x     = rc[0];
  assign rot_y     = rc[1];
  assign rot_z     = rc[2];
  assign zero_quat = zq;
  assign saturated = sat;

`ifndef SYNTH
  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_quat |-> rot_x == '0 && rot_y == '0 && rot_z == '0 && !saturated)
    else $error("zero quaternion result not cleared");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output slot");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");
`endif
endmodule
`default_nettype wire
